[rtl/assert_macros.svh]
// Assertion macros shared by the translation buffer RTL.
// Needs a clock named clk and an active-low reset named rst_n in the module that uses them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition that must never be true outside reset.
`define ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

[rtl/atlb_pkg.sv]
// Package for the identifier-tagged translation buffer: widths, operation codes and
// the structs passed between controller and cells. No dependencies.
`timescale 1ns / 1ps

package atlb_pkg;

  localparam int PAGE_W      = 52;
  localparam int ASID_W      = 16;
  localparam int KIND_W      = 2;
  localparam int ENTRIES_DEF = 64;
  localparam int IN_DATA_W   = 104;
  localparam int OUT_DATA_W  = 56;

  typedef logic [PAGE_W-1:0] page_t;
  typedef logic [ASID_W-1:0] asid_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_LOOKUP = 2'd0,
    KIND_ADD    = 2'd1,
    KIND_FLUSH  = 2'd2
  } atlb_kind_t;

  // Search token handed from one cell to the next.
  typedef struct packed {
    logic  valid;
    logic  hit;
    page_t page;
  } atlb_tok_t;

  // Write and flush command broadcast to every cell.
  typedef struct packed {
    logic  we;
    logic  flush;
    page_t tag;
    page_t frame;
    asid_t space;
  } atlb_wr_t;

endpackage

[rtl/asid_tagged_fifo_tlb.sv]
// Top level of the identifier-tagged, fully associative translation buffer.
// Depends on atlb_pkg, atlb_cell, atlb_ctrl and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Channel   Direction  Handshake          Payload
// in_       slave      tvalid / tready    tuser: kind; tdata: virt_page, phys_page
// out_      master     tvalid / tready    tuser: hit; tdata: found_page
// cfg_      write      wr_en              wr_data: current_asid
//
// A lookup travels down a chain of ENTRIES cells, one cell per cycle, before the
// controller holds its result; an add or a flush goes straight to the result state.
// The chain length sets how long a lookup is in work; one item is in work at a time.
// Reset (rst_n low at a clock edge) empties the buffer and zeroes fill count and pointer.
// A result waiting in the output register does not block acceptance of the next item;
// only that item's own result waits until the output register is free.

module asid_tagged_fifo_tlb
  import atlb_pkg::*;
#(
  parameter int ENTRIES = ENTRIES_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // virt_page [51:0], phys_page [103:52]
  input  logic [KIND_W-1:0]     in_tuser,   // kind [1:0]
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // found_page [51:0], zero fill [55:52]
  output logic                  out_tuser,  // hit [0]
  input  logic                  cfg_wr_en,
  input  logic [ASID_W-1:0]     cfg_wr_data // current_asid [15:0]
);

  localparam int IDXW = $clog2(ENTRIES);
  localparam int FCW  = $clog2(ENTRIES + 1);

  asid_t           asid_r;
  atlb_wr_t        wr;
  logic [IDXW-1:0] wr_idx;
  page_t           query_page;
  atlb_tok_t       tok_w [0:ENTRIES];
  logic            res_valid;
  logic            res_hit;
  page_t           res_page;
  logic            res_take;
  logic            out_valid_r;
  logic            out_hit_r;
  page_t           out_page_r;

  // The identifier register; the user must change it only while idle, the block does not enforce it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      asid_r <= '0;
    end else if (cfg_wr_en) begin
      asid_r <= cfg_wr_data;
    end
  end

  atlb_ctrl #(
    .ENTRIES (ENTRIES),
    .IDXW    (IDXW),
    .FCW     (FCW)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_kind    (in_tuser),
    .in_virt    (in_tdata[PAGE_W-1:0]),
    .in_phys    (in_tdata[2*PAGE_W-1:PAGE_W]),
    .asid       (asid_r),
    .wr         (wr),
    .wr_idx     (wr_idx),
    .query_page (query_page),
    .tok_inj    (tok_w[0]),
    .tok_ret    (tok_w[ENTRIES]),
    .res_valid  (res_valid),
    .res_hit    (res_hit),
    .res_page   (res_page),
    .res_take   (res_take)
  );

  // The cell chain: cell 0 sees the search first, so the lowest matching
  // index keeps its answer as the token moves on.
  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    logic sel;
    assign sel = wr.we && (wr_idx == IDXW'(i));
    atlb_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .wr         (wr),
      .wr_sel     (sel),
      .query_page (query_page),
      .query_asid (asid_r),
      .tok_in     (tok_w[i]),
      .tok_out    (tok_w[i+1])
    );
  end

  // Output register: loads the finished result when it is empty or being drained.
  assign res_take = res_valid && (!out_valid_r || out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_take) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      out_hit_r  <= res_hit;
      out_page_r <= res_page;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_hit_r;
  assign out_tdata  = {{(OUT_DATA_W - PAGE_W){1'b0}}, out_page_r};

  // A miss or a non-lookup result always carries a zero page.
  `ASSERT_CLK(a_miss_zero, (out_valid_r && !out_hit_r) |-> (out_page_r == '0), "miss with nonzero page")

endmodule

[rtl/atlb_cell.sv]
// One entry of the translation buffer and one stage of the search chain.
// Depends on atlb_pkg.
`timescale 1ns / 1ps

module atlb_cell
  import atlb_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  atlb_wr_t  wr,
  input  logic      wr_sel,
  input  page_t     query_page,
  input  asid_t     query_asid,
  input  atlb_tok_t tok_in,
  output atlb_tok_t tok_out
);

  page_t     tag_r;
  page_t     frame_r;
  asid_t     space_r;
  logic      occ_r;
  logic      occ_nxt;
  atlb_tok_t tok_r;
  atlb_tok_t tok_nxt;
  logic      match;

  assign match = occ_r && (tag_r == query_page) && (space_r == query_asid);

  always_comb begin
    occ_nxt = occ_r;
    if (wr.flush) begin
      occ_nxt = 1'b0;
    end else if (wr_sel) begin
      occ_nxt = 1'b1;
    end
  end

  // An earlier cell's hit has priority, so the lowest index wins.
  always_comb begin
    tok_nxt.valid = tok_in.valid;
    tok_nxt.hit   = tok_in.hit | match;
    if (tok_in.hit) begin
      tok_nxt.page = tok_in.page;
    end else if (match) begin
      tok_nxt.page = frame_r;
    end else begin
      tok_nxt.page = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r       <= 1'b0;
      tok_r.valid <= 1'b0;
    end else begin
      occ_r       <= occ_nxt;
      tok_r.valid <= tok_nxt.valid;
    end
    tok_r.hit  <= tok_nxt.hit;
    tok_r.page <= tok_nxt.page;
  end

  always_ff @(posedge clk) begin
    if (wr_sel) begin
      tag_r   <= wr.tag;
      frame_r <= wr.frame;
      space_r <= wr.space;
    end
  end

  assign tok_out = tok_r;

endmodule

[rtl/atlb_ctrl.sv]
// Operation sequencer: fill count, replacement pointer, search launch and result hold.
// Depends on atlb_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module atlb_ctrl
  import atlb_pkg::*;
#(
  parameter int ENTRIES = ENTRIES_DEF,
  parameter int IDXW    = $clog2(ENTRIES),
  parameter int FCW     = $clog2(ENTRIES + 1)
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [KIND_W-1:0] in_kind,
  input  page_t           in_virt,
  input  page_t           in_phys,
  input  asid_t           asid,
  output atlb_wr_t        wr,
  output logic [IDXW-1:0] wr_idx,
  output page_t           query_page,
  output atlb_tok_t       tok_inj,
  input  atlb_tok_t       tok_ret,
  output logic            res_valid,
  output logic            res_hit,
  output page_t           res_page,
  input  logic            res_take
);

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_SEARCH = 3'b010,
    ST_RESULT = 3'b100
  } state_t;

  state_t          state_r, state_nxt;
  logic [FCW-1:0]  fill_count_r, fill_count_nxt;
  logic [IDXW-1:0] ptr_r, ptr_nxt;
  page_t           query_r, query_nxt;
  logic            inj_r, inj_nxt;
  logic            hit_r, hit_nxt;
  page_t           page_r, page_nxt;
  logic            accept;
  logic            full;

  assign in_ready = (state_r == ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign full     = (fill_count_r == FCW'(ENTRIES));

  always_comb begin
    state_nxt      = state_r;
    fill_count_nxt = fill_count_r;
    ptr_nxt        = ptr_r;
    query_nxt      = query_r;
    inj_nxt        = 1'b0;
    hit_nxt        = hit_r;
    page_nxt       = page_r;
    wr.we          = 1'b0;
    wr.flush       = 1'b0;
    wr.tag         = in_virt;
    wr.frame       = in_phys;
    wr.space       = asid;
    wr_idx         = fill_count_r[IDXW-1:0];
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          hit_nxt   = 1'b0;
          page_nxt  = '0;
          state_nxt = ST_RESULT;
          unique case (atlb_kind_t'(in_kind))
            KIND_LOOKUP: begin
              query_nxt = in_virt;
              inj_nxt   = 1'b1;
              state_nxt = ST_SEARCH;
            end
            KIND_ADD: begin
              wr.we = 1'b1;
              if (!full) begin
                fill_count_nxt = fill_count_r + FCW'(1);
              end else begin
                // Every slot is occupied and valid: replace round-robin.
                wr_idx  = ptr_r;
                ptr_nxt = (ptr_r == IDXW'(ENTRIES - 1)) ? '0 : ptr_r + IDXW'(1);
              end
            end
            KIND_FLUSH: begin
              wr.flush       = 1'b1;
              fill_count_nxt = '0;
            end
            default: begin
            end
          endcase
        end
      end
      ST_SEARCH: begin
        if (tok_ret.valid) begin
          hit_nxt   = tok_ret.hit;
          page_nxt  = tok_ret.page;
          state_nxt = ST_RESULT;
        end
      end
      ST_RESULT: begin
        if (res_take) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      fill_count_r <= '0;
      ptr_r        <= '0;
      inj_r        <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      fill_count_r <= fill_count_nxt;
      ptr_r        <= ptr_nxt;
      inj_r        <= inj_nxt;
    end
  end

  always_ff @(posedge clk) begin
    query_r <= query_nxt;
    hit_r   <= hit_nxt;
    page_r  <= page_nxt;
  end

  assign query_page    = query_r;
  assign tok_inj.valid = inj_r;
  assign tok_inj.hit   = 1'b0;
  assign tok_inj.page  = '0;
  assign res_valid     = (state_r == ST_RESULT);
  assign res_hit       = hit_r;
  assign res_page      = page_r;

  `ASSERT_NEVER(a_fill_bound, fill_count_r > FCW'(ENTRIES), "fill count above capacity")
  `ASSERT_CLK(a_ret_in_search, tok_ret.valid |-> state_r == ST_SEARCH, "token outside search")
  `ASSERT_CLK(a_ptr_when_full, (ptr_r != $past(ptr_r)) |-> $past(full), "pointer moved early")

endmodule
